>>> rtl/core/rffc_pkg.sv
// Shared types, constants and elaboration-time table functions for the
// RMS feed-forward compressor. No dependencies.
package rffc_pkg;

  localparam int RFFC_SAMPLE_BITS = 16;
  localparam int RFFC_LOG_DEPTH   = 256;

  localparam int RFFC_CFG_IDX_W  = 3;
  localparam int RFFC_CFG_DATA_W = 18;
  localparam int RFFC_S_DATA_W   = 32;
  localparam int RFFC_M_DATA_W   = 56;

  localparam logic [17:0] RFFC_DB_PER_OCT = 18'd197283;
  localparam logic [21:0] RFFC_OCT_PER_DB = 22'd2786635;
  localparam logic signed [15:0] RFFC_LEVEL_FLOOR = -16'sd24576;
  localparam logic [16:0] RFFC_UNITY = 17'h10000;

  typedef enum logic [2:0] {
    REG_THRESHOLD   = 3'd0,
    REG_SLOPE       = 3'd1,
    REG_ATTACK      = 3'd2,
    REG_RELEASE     = 3'd3,
    REG_AVERAGE     = 3'd4,
    REG_WET_MIX     = 3'd5,
    REG_GAIN_PRESET = 3'd6
  } rffc_reg_e;

  // Operand selection for the shared multiplier.
  typedef enum logic [3:0] {
    M_NONE, M_SQ, M_MP, M_SQA, M_LDB, M_ATT, M_EXP, M_ROOT,
    M_G1, M_G2, M_WET, M_MIX1, M_MIX2
  } rffc_msel_t;

  // Writeback action taken on the registered product or on other datapath state.
  typedef enum logic [3:0] {
    W_NONE, W_SQ, W_ACCLD, W_MP, W_NINIT, W_NORM, W_ROM, W_LDB, W_ATT,
    W_EXP, W_ROOT, W_TGT, W_G, W_WET, W_MIX
  } rffc_wsel_t;

  typedef struct packed {
    rffc_msel_t msel;
    rffc_wsel_t wsel;
    logic       side;
    logic [3:0] k;
    logic       load;
    logic       emit;
  } rffc_cmd_t;

  typedef struct packed {
    logic [15:0] threshold;
    logic [15:0] slope;
    logic [15:0] attack;
    logic [15:0] release_c;
    logic [15:0] average;
    logic [16:0] wet_mix;
    logic        g_load;
    logic [17:0] g_value;
  } rffc_cfg_t;

  function automatic logic [63:0] rffc_isqrt(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = val;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q0.30 value of 2^-(2^-(k+1)).
  function automatic logic [29:0] rffc_root(input int k);
    logic [63:0] r;
    r = rffc_isqrt(64'd1 << 59);
    for (int j = 1; j < 16; j++) begin
      if (j <= k) r = rffc_isqrt(r << 30);
    end
    return r[29:0];
  endfunction

  // Q0.16 value of log2(1 + i/2^lb), by repeated squaring.
  function automatic logic [15:0] rffc_log_entry(input int i, input int lb);
    logic [63:0] v;
    logic [15:0] r;
    v = 64'((64'd1 << lb) + 64'(i)) << (30 - lb);
    r = 16'd0;
    for (int j = 0; j < 16; j++) begin
      v = (v * v) >> 30;
      r = r << 1;
      if (v >= (64'd1 << 31)) begin
        r = r | 16'd1;
        v = v >> 1;
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/core/rffc_regs.sv
// Configuration register file of the compressor.
// Depends on rffc_pkg.
module rffc_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [rffc_pkg::RFFC_CFG_IDX_W-1:0]  cfg_index,
  input  logic [rffc_pkg::RFFC_CFG_DATA_W-1:0] cfg_data,
  output rffc_pkg::rffc_cfg_t                 cfg
);
  import rffc_pkg::*;

  logic [15:0] threshold, slope, attack, release_c, average;
  logic [16:0] wet_mix;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= 16'hEC00;
      slope     <= 16'd32768;
      attack    <= 16'd655;
      release_c <= 16'd66;
      average   <= 16'd655;
      wet_mix   <= RFFC_UNITY;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_THRESHOLD: threshold <= cfg_data[15:0];
        REG_SLOPE:     slope     <= cfg_data[15:0];
        REG_ATTACK:    attack    <= cfg_data[15:0];
        REG_RELEASE:   release_c <= cfg_data[15:0];
        REG_AVERAGE:   average   <= cfg_data[15:0];
        REG_WET_MIX:   wet_mix   <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // Writing the preset loads the gain smoother directly.
  always_comb begin
    cfg.threshold = threshold;
    cfg.slope     = slope;
    cfg.attack    = attack;
    cfg.release_c = release_c;
    cfg.average   = average;
    cfg.wet_mix   = wet_mix;
    cfg.g_load    = cfg_valid && (cfg_index == REG_GAIN_PRESET);
    cfg.g_value   = cfg_data;
  end

endmodule

>>> rtl/core/rffc_ctrl.sv
// Sequencer of the compressor: steps the shared datapath through the detector,
// gain computer and smoother for each channel, then the mixes.
// Depends on rffc_pkg.
module rffc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_free,
  output logic                in_ready,
  output rffc_pkg::rffc_cmd_t cmd
);
  import rffc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_MIX, S_EMIT} state_t;

  localparam logic [5:0] STEP_LAST  = 6'd54;
  localparam logic [5:0] ROOT_FIRST = 6'd17;
  localparam logic [5:0] ROOT_LAST  = 6'd48;
  localparam logic [5:0] NORM_FIRST = 6'd5;
  localparam logic [5:0] MIX_LAST   = 6'd2;

  state_t     state;
  logic       side;
  logic [5:0] pc;
  logic [5:0] rel;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      side  <= 1'b0;
      pc    <= 6'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_RUN;
            side  <= 1'b0;
            pc    <= 6'd0;
          end
        end
        S_RUN: begin
          if (pc == STEP_LAST) begin
            pc <= 6'd0;
            if (side) begin
              state <= S_MIX;
              side  <= 1'b0;
            end else begin
              side <= 1'b1;
            end
          end else begin
            pc <= pc + 6'd1;
          end
        end
        S_MIX: begin
          if (pc == MIX_LAST) begin
            pc <= 6'd0;
            if (side) state <= S_EMIT;
            else side <= 1'b1;
          end else begin
            pc <= pc + 6'd1;
          end
        end
        S_EMIT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    rel      = pc - ROOT_FIRST;
    cmd.msel = M_NONE;
    cmd.wsel = W_NONE;
    cmd.side = side;
    cmd.k    = 4'd0;
    cmd.load = (state == S_IDLE) && in_valid;
    cmd.emit = (state == S_EMIT) && out_free;
    if (state == S_RUN) begin
      if (pc >= ROOT_FIRST && pc <= ROOT_LAST) begin
        cmd.k = rel[4:1];
        if (rel[0]) cmd.wsel = W_ROOT;
        else cmd.msel = M_ROOT;
      end else begin
        case (pc)
          6'd0:  cmd.msel = M_SQ;
          6'd1:  begin cmd.wsel = W_SQ;    cmd.msel = M_MP;  end
          6'd2:  begin cmd.wsel = W_ACCLD; cmd.msel = M_SQA; end
          6'd3:  cmd.wsel = W_MP;
          6'd4:  cmd.wsel = W_NINIT;
          6'd5, 6'd6, 6'd7, 6'd8, 6'd9: begin
            cmd.wsel = W_NORM;
            cmd.k    = 4'(pc - NORM_FIRST);
          end
          6'd10: cmd.wsel = W_ROM;
          6'd11: cmd.msel = M_LDB;
          6'd12: cmd.wsel = W_LDB;
          6'd13: cmd.msel = M_ATT;
          6'd14: cmd.wsel = W_ATT;
          6'd15: cmd.msel = M_EXP;
          6'd16: cmd.wsel = W_EXP;
          6'd49: cmd.wsel = W_TGT;
          6'd50: cmd.msel = M_G1;
          6'd51: begin cmd.wsel = W_ACCLD; cmd.msel = M_G2; end
          6'd52: cmd.wsel = W_G;
          6'd53: cmd.msel = M_WET;
          6'd54: cmd.wsel = W_WET;
          default: ;
        endcase
      end
    end else if (state == S_MIX) begin
      case (pc)
        6'd0: cmd.msel = M_MIX1;
        6'd1: begin cmd.wsel = W_ACCLD; cmd.msel = M_MIX2; end
        6'd2: cmd.wsel = W_MIX;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/rffc_dp.sv
// Datapath of the compressor: one shared registered multiplier, accumulator,
// normalizer, log and root tables, detector and smoother state.
// Depends on rffc_pkg.
module rffc_dp #(
  parameter int SAMPLE_BITS     = rffc_pkg::RFFC_SAMPLE_BITS,
  parameter int LOG_TABLE_DEPTH = rffc_pkg::RFFC_LOG_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  rffc_pkg::rffc_cmd_t cmd,
  input  rffc_pkg::rffc_cfg_t cfg,
  input  logic [15:0]         left_in,
  input  logic [15:0]         right_in,
  output logic [15:0]         left_out,
  output logic [15:0]         right_out,
  output logic [17:0]         gain
);
  import rffc_pkg::*;

  localparam int S     = SAMPLE_BITS;
  localparam int LB    = $clog2(LOG_TABLE_DEPTH);
  localparam int SQ_SH = 2 * S - 2;
  localparam int SQ_R  = (SQ_SH >= 31) ? SQ_SH - 31 : 0;
  localparam int SQ_L  = (SQ_SH < 31) ? 31 - SQ_SH : 0;
  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (S - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

  logic [15:0] log_tab [LOG_TABLE_DEPTH];
  logic [29:0] root_tab [16];

  for (genvar i = 0; i < LOG_TABLE_DEPTH; i++) begin : g_log
    localparam logic [15:0] LV = rffc_log_entry(i, LB);
    assign log_tab[i] = LV;
  end
  for (genvar i = 0; i < 16; i++) begin : g_root
    localparam logic [29:0] RV = rffc_root(i);
    assign root_tab[i] = RV;
  end

  logic signed [S-1:0]   xl, xr, x;
  logic signed [S+1:0]   wet_l, wet_r, wet;
  logic [31:0]           sq, mp, norm;
  logic [4:0]            sh;
  logic [15:0]           rom_q;
  logic signed [15:0]    lvl;
  logic                  over_pos;
  logic [16:0]           att, tgt;
  logic [22:0]           e;
  logic [30:0]           v;
  logic [17:0]           g;
  logic signed [63:0]    acc, prod, mprod, sum, mixs, db;
  logic signed [32:0]    ma;
  logic signed [30:0]    mb;
  logic signed [22:0]    lval;
  logic signed [16:0]    over;
  logic [15:0]           c;
  logic [16:0]           inv_c, inv_a, w, inv_w;
  logic [4:0]            amt;
  logic [31:0]           top_mask;
  logic [7:0]            n;
  logic [S-1:0]          lraw, rraw;
  logic signed [15:0]    thr;

  assign x     = cmd.side ? xr : xl;
  assign wet   = cmd.side ? wet_r : wet_l;
  assign thr   = cfg.threshold;
  assign lval  = $signed({7'd0, rom_q}) - $signed({2'd0, sh, 16'd0});
  assign over  = $signed({lvl[15], lvl}) - $signed({thr[15], thr});
  assign c     = ({1'b0, tgt} < g) ? cfg.attack : cfg.release_c;
  assign inv_c = RFFC_UNITY - {1'b0, c};
  assign inv_a = RFFC_UNITY - {1'b0, cfg.average};
  assign w     = (cfg.wet_mix > RFFC_UNITY) ? RFFC_UNITY : cfg.wet_mix;
  assign inv_w = RFFC_UNITY - w;
  assign amt   = 5'd16 >> cmd.k[2:0];
  assign top_mask = ~(32'hFFFF_FFFF >> amt);
  assign n     = {1'b0, e[22:16]} + 8'd14;
  assign sum   = acc + prod;
  assign mixs  = sum >>> 16;
  assign db    = prod >>> 24;
  assign lraw  = S'(left_in);
  assign rraw  = S'(right_in);

  always_comb begin
    ma = 33'sd0;
    mb = 31'sd0;
    case (cmd.msel)
      M_SQ:   begin ma = 33'(x);   mb = 31'(x); end
      M_MP:   begin ma = 33'(mp);  mb = 31'(inv_a); end
      M_SQA:  begin ma = 33'(sq);  mb = 31'(cfg.average); end
      M_LDB:  begin ma = 33'(lval); mb = 31'(RFFC_DB_PER_OCT); end
      M_ATT:  begin ma = 33'(over); mb = 31'(cfg.slope); end
      M_EXP:  begin ma = 33'(att); mb = 31'(RFFC_OCT_PER_DB); end
      M_ROOT: begin ma = 33'(v);   mb = 31'(root_tab[cmd.k]); end
      M_G1:   begin ma = 33'(g);   mb = 31'(inv_c); end
      M_G2:   begin ma = 33'(tgt); mb = 31'(c); end
      M_WET:  begin ma = 33'(g);   mb = 31'(x); end
      M_MIX1: begin ma = 33'(wet); mb = 31'(w); end
      M_MIX2: begin ma = 33'(x);   mb = 31'(inv_w); end
      default: ;
    endcase
  end

  assign mprod = ma * mb;

  // Detector and smoother state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mp <= 32'd0;
      g  <= 18'h10000;
    end else begin
      if (cmd.wsel == W_MP) mp <= sum[47:16];
      if (cfg.g_load) g <= cfg.g_value;
      else if (cmd.wsel == W_G) g <= sum[33:16];
    end
  end

  always_ff @(posedge clk) begin
    prod <= mprod;
    if (cmd.load) begin
      xl <= signed'(lraw);
      xr <= signed'(rraw);
    end
    case (cmd.wsel)
      W_SQ:    sq <= 32'((prod >> SQ_R) << SQ_L);
      W_ACCLD: acc <= prod;
      W_NINIT: begin
        norm <= mp;
        sh   <= 5'd0;
      end
      W_NORM: begin
        if ((norm & top_mask) == 32'd0) begin
          norm <= norm << amt;
          sh   <= sh + amt;
        end
      end
      W_ROM:   rom_q <= log_tab[norm[30 -: LB]];
      W_LDB: begin
        v <= 31'h4000_0000;
        if (!norm[31] || db < 64'(RFFC_LEVEL_FLOOR)) lvl <= RFFC_LEVEL_FLOOR;
        else lvl <= db[15:0];
      end
      W_ATT: begin
        att      <= prod[32:16];
        over_pos <= !over[16] && (over != 17'sd0);
      end
      W_EXP:   e <= prod[38:16];
      W_ROOT:  if (e[4'd15 - cmd.k]) v <= prod[60:30];
      W_TGT: begin
        if (!over_pos) tgt <= RFFC_UNITY;
        else if (n >= 8'd31) tgt <= 17'd0;
        else tgt <= 17'(v >> n);
      end
      W_WET: begin
        if (cmd.side) wet_r <= (S+2)'(prod >>> 16);
        else wet_l <= (S+2)'(prod >>> 16);
      end
      W_MIX: begin
        if (cmd.side) begin
          right_out <= (mixs > SAT_HI) ? SAT_HI[15:0] :
                       (mixs < SAT_LO) ? SAT_LO[15:0] : mixs[15:0];
        end else begin
          left_out <= (mixs > SAT_HI) ? SAT_HI[15:0] :
                      (mixs < SAT_LO) ? SAT_LO[15:0] : mixs[15:0];
        end
      end
      default: ;
    endcase
  end

  assign gain = g;

endmodule

>>> rtl/core/rms_feedforward_compressor.sv
// Top level of the stereo RMS feed-forward compressor.
// Depends on rffc_pkg, rffc_regs, rffc_ctrl and rffc_dp.
//
// The block takes one stereo frame per item and returns one item holding the
// two mixed samples and the smoothed gain after the right step. A frame runs
// through the left channel step, the right channel step, then the left and
// right mixes before its result is registered, because one shared multiplier
// with a registered product serves every product in the path; each channel
// step includes the 16-step product of root constants that turns the gain in
// dB into a linear factor. One frame is worked on at a time; a new frame is
// taken as soon as the previous result sits in the output register, even if
// that result has not been taken yet. Configuration writes are always accepted
// and are meant to happen while no frame is in flight; writing the gain preset
// also loads the gain smoother. The log table is built at elaboration from
// LOG_TABLE_DEPTH, which must be a power of two.
module rms_feedforward_compressor #(
  parameter int SAMPLE_BITS     = rffc_pkg::RFFC_SAMPLE_BITS,
  parameter int LOG_TABLE_DEPTH = rffc_pkg::RFFC_LOG_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // left_in [15:0], right_in [31:16]
  input  logic [rffc_pkg::RFFC_S_DATA_W-1:0]   s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // left_out [15:0], right_out [31:16], gain_now [49:32], zero [55:50]
  output logic [rffc_pkg::RFFC_M_DATA_W-1:0]   m_axis_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rffc_pkg::RFFC_CFG_IDX_W-1:0]  cfg_index,
  input  logic [rffc_pkg::RFFC_CFG_DATA_W-1:0] cfg_data
);
  import rffc_pkg::*;

  rffc_cfg_t   cfg;
  rffc_cmd_t   cmd;
  logic        out_free;
  logic [15:0] left_out, right_out;
  logic [17:0] gain_now;

  assign cfg_ready = 1'b1;
  // The result register can take a new item when empty or being drained.
  assign out_free = !m_axis_tvalid || m_axis_tready;

  rffc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rffc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .out_free (out_free),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  rffc_dp #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .left_in   (s_axis_tdata[15:0]),
    .right_in  (s_axis_tdata[31:16]),
    .left_out  (left_out),
    .right_out (right_out),
    .gain      (gain_now)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) m_axis_tdata <= {6'd0, gain_now, right_out, left_out};
  end

endmodule

>>> rtl/core/rffc_checker.sv
// Port-level checks of the compressor, bound to its top level.
// Depends on rffc_pkg and rms_feedforward_compressor.
module rffc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [rffc_pkg::RFFC_M_DATA_W-1:0] m_axis_tdata
);
  import rffc_pkg::*;

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Padding above the gain is always zero.
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[55:50] == 6'd0)
    else $error("result padding not zero");

  // One frame at a time: no second item is taken right after one.
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // A frame needs many cycles, so no result appears right after acceptance.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result too early");

endmodule

bind rms_feedforward_compressor rffc_checker u_rffc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> verif/tb.sv
// Self-checking testbench for the stereo RMS feed-forward compressor.
// Depends on rffc_pkg and on the RTL below rms_feedforward_compressor.
module tb;
  import rffc_pkg::*;

  // Index 7 lies beyond the register list; a write to it must change nothing.
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 140;
  localparam longint LEVEL_MIN = -24576;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [17:0]        gain;
  } frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [RFFC_S_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [RFFC_M_DATA_W-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [RFFC_CFG_IDX_W-1:0] cfg_index = '0;
  logic [RFFC_CFG_DATA_W-1:0] cfg_data = '0;

  rms_feedforward_compressor dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state: a private copy of the registers, the detector and the smoother.
  longint cfg_thr, cfg_slope, cfg_attack, cfg_release, cfg_average, cfg_wet, cfg_preset;
  longint mean_pow, gain_state;
  longint log_tab[256];
  longint root_tab[16];

  frame_t expected_frames[$];
  int fail_count = 0;
  int frames_sent = 0;
  int frames_checked = 0;
  int cfg_writes = 0;
  bit rx_no_stall = 1'b0;
  bit tx_no_gap = 1'b0;

  function automatic longint int_sqrt(longint val);
    longint v, r, b;
    v = val;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2(1 + i/256) in Q0.16 by repeated squaring, and the Q0.30 roots
  // 2^-(2^-(k+1)) used to build the linear gain bit by bit.
  function automatic void build_tables();
    longint v;
    longint r;
    for (int i = 0; i < 256; i++) begin
      v = longint'(256 + i) << 22;
      r = 0;
      for (int k = 0; k < 16; k++) begin
        v = (v * v) >> 30;
        r = r << 1;
        if (v >= (64'sd1 << 31)) begin
          r = r | 1;
          v = v >> 1;
        end
      end
      log_tab[i] = r;
    end
    root_tab[0] = int_sqrt(64'sd1 << 59);
    for (int k = 1; k < 16; k++) root_tab[k] = int_sqrt(root_tab[k-1] << 30);
  endfunction

  function automatic longint level_of_power(longint p);
    int msb;
    longint frac, idx, l, db;
    if (p == 0) return LEVEL_MIN;
    msb = 31;
    while (((p >> msb) & 1) == 0) msb--;
    frac = (p << (31 - msb)) - (64'sd1 << 31);
    idx = (frac * 256) >> 31;
    if (idx > 255) idx = 255;
    l = longint'(msb - 31) * 65536 + log_tab[idx];
    db = (l * 197283) >>> 24;
    if (db < LEVEL_MIN) db = LEVEL_MIN;
    return db;
  endfunction

  function automatic longint gain_for_level(longint level);
    longint thr, over, att, e, v, n;
    thr = longint'($signed(cfg_thr[15:0]));
    over = level - thr;
    if (over <= 0) return 65536;
    att = (over * cfg_slope) >> 16;
    e = (att * 2786635) >> 16;
    v = 64'sd1 << 30;
    for (int k = 0; k < 16; k++)
      if (((e >> (15 - k)) & 1) != 0) v = (v * root_tab[k]) >> 30;
    n = (e >> 16) + 14;
    if (n >= 64) return 0;
    return v >> n;
  endfunction

  // One detector and smoother step; returns the gain-scaled sample.
  function automatic longint compress_sample(longint x);
    longint sq, tgt, c;
    sq = (x * x) << 1;
    mean_pow = ((mean_pow * (65536 - cfg_average) + sq * cfg_average) >> 16) & 64'hFFFF_FFFF;
    tgt = gain_for_level(level_of_power(mean_pow));
    c = (tgt < gain_state) ? cfg_attack : cfg_release;
    gain_state = ((gain_state * (65536 - c) + tgt * c) >> 16) & 64'h3FFFF;
    return (gain_state * x) >>> 16;
  endfunction

  function automatic logic signed [15:0] mix_sample(longint wet, longint dry);
    longint w, s;
    w = (cfg_wet > 65536) ? 65536 : cfg_wet;
    s = (w * wet + (65536 - w) * dry) >>> 16;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return s[15:0];
  endfunction

  function automatic frame_t predict_frame(logic [15:0] l_in, logic [15:0] r_in);
    frame_t f;
    longint l, r, lw, rw;
    l = longint'($signed(l_in));
    r = longint'($signed(r_in));
    lw = compress_sample(l);
    rw = compress_sample(r);
    f.left = mix_sample(lw, l);
    f.right = mix_sample(rw, r);
    f.gain = gain_state[17:0];
    return f;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [17:0] value);
    case (idx)
      REG_THRESHOLD:   cfg_thr = value[15:0];
      REG_SLOPE:       cfg_slope = value[15:0];
      REG_ATTACK:      cfg_attack = value[15:0];
      REG_RELEASE:     cfg_release = value[15:0];
      REG_AVERAGE:     cfg_average = value[15:0];
      REG_WET_MIX:     cfg_wet = value[16:0];
      REG_GAIN_PRESET: begin
        cfg_preset = value;
        gain_state = value;
      end
      default: ;
    endcase
  endfunction

  // Result side: ready drops for mostly short stalls, now and then long ones.
  int stall_left = 0;
  always @(negedge clk) begin
    if (rx_no_stall) begin
      m_axis_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 70) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200)
                                                 : $urandom_range(0, 3);
    end
  end

  // Each result item is compared with the oldest expectation.
  always @(posedge clk) begin
    frame_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected result item %h", $time, m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_frames.pop_front();
        frames_checked++;
        if (m_axis_tdata[15:0] !== want.left) begin
          $display("%0t: left_out expected %0d actual %0d", $time, want.left,
                   $signed(m_axis_tdata[15:0]));
          fail_count++;
        end
        if (m_axis_tdata[31:16] !== want.right) begin
          $display("%0t: right_out expected %0d actual %0d", $time, want.right,
                   $signed(m_axis_tdata[31:16]));
          fail_count++;
        end
        if (m_axis_tdata[49:32] !== want.gain) begin
          $display("%0t: gain_now expected %0d actual %0d", $time, want.gain,
                   m_axis_tdata[49:32]);
          fail_count++;
        end
      end
    end
  end

  // The watchdog restarts whenever any channel moves an item.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time,
               expected_frames.size());
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one frame; valid stays high into the next frame when no gap is drawn.
  task automatic send_frame(logic [15:0] l_in, logic [15:0] r_in);
    int gap;
    @(negedge clk);
    gap = 0;
    if (!tx_no_gap)
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {r_in, l_in};
    do @(posedge clk); while (!s_axis_tready);
    expected_frames.push_back(predict_frame(l_in, r_in));
    frames_sent++;
  endtask

  // Waits until every result has arrived and the datapath has gone quiet.
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [17:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, value);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_some(int count);
    for (int i = 0; i < count; i++)
      send_frame(16'($urandom), 16'($urandom));
  endtask

  // Reset settings: silence hits the -96 dB floor, full-scale extremes push
  // the gain down, and the sign extremes drive both ends of the input range.
  task automatic test_defaults();
    logic [15:0] pattern [0:11];
    pattern = '{16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
                16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h4000, 16'hC000};
    for (int i = 0; i < 12; i += 2) send_frame(pattern[i], pattern[i+1]);
    for (int i = 0; i < 8; i++) send_frame(16'h7FFF, 16'h8001);
    drain();
  endtask

  // Every register at its extremes, wet mix above full scale, and a write
  // to an index past the list, each followed by a few frames.
  task automatic test_registers();
    write_reg(REG_AVERAGE, 18'd65535);
    write_reg(REG_ATTACK, 18'd65535);
    write_reg(REG_RELEASE, 18'd0);
    write_reg(REG_SLOPE, 18'd65535);
    write_reg(REG_THRESHOLD, 18'(-24576));
    write_reg(REG_WET_MIX, 18'd0);
    write_reg(REG_GAIN_PRESET, 18'd262143);
    send_some(6);
    drain();
    write_reg(REG_WET_MIX, 18'd131071);
    write_reg(REG_THRESHOLD, 18'h08000);
    write_reg(REG_RELEASE, 18'd65535);
    write_reg(REG_UNUSED, 18'h3FFFF);
    send_some(6);
    drain();
    write_reg(REG_THRESHOLD, 18'd0);
    write_reg(REG_SLOPE, 18'd0);
    write_reg(REG_ATTACK, 18'd0);
    write_reg(REG_AVERAGE, 18'd0);
    write_reg(REG_WET_MIX, 18'd65536);
    write_reg(REG_GAIN_PRESET, 18'd0);
    send_some(6);
    drain();
  endtask

  // Random settings per phase with program-like content: quiet passages, loud
  // bursts and silence so the detector and smoother swing through their range.
  task automatic test_random_phases(int phases, int per_phase);
    int kind;
    int shift;
    logic [15:0] l_in, r_in;
    for (int p = 0; p < phases; p++) begin
      write_reg(REG_THRESHOLD, 18'(-$urandom_range(0, 24576)));
      write_reg(REG_SLOPE, ($urandom_range(0, 3) == 0) ? 18'd65535 : 18'($urandom_range(0, 65535)));
      write_reg(REG_ATTACK, 18'($urandom_range(0, 65535) >> $urandom_range(0, 10)));
      write_reg(REG_RELEASE, 18'($urandom_range(0, 65535) >> $urandom_range(0, 12)));
      write_reg(REG_AVERAGE, 18'($urandom_range(0, 65535) >> $urandom_range(0, 8)));
      write_reg(REG_WET_MIX, ($urandom_range(0, 4) == 0) ? 18'($urandom_range(0, 131071))
                                                         : 18'($urandom_range(0, 65536)));
      if ($urandom_range(0, 2) == 0) write_reg(REG_GAIN_PRESET, 18'($urandom_range(0, 262143)));
      if ($urandom_range(0, 5) == 0) write_reg(REG_UNUSED, 18'($urandom));
      rx_no_stall = ($urandom_range(0, 3) == 0);
      tx_no_gap = ($urandom_range(0, 3) == 0);
      kind = 0;
      for (int i = 0; i < per_phase; i++) begin
        if (i % 20 == 0) kind = $urandom_range(0, 3);
        shift = (kind == 0) ? $urandom_range(0, 15) : (kind == 1) ? $urandom_range(8, 15) : 0;
        l_in = 16'($signed(16'($urandom)) >>> shift);
        r_in = 16'($signed(16'($urandom)) >>> shift);
        if (kind == 3) begin
          l_in = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'h0000;
          r_in = 16'h0000;
        end
        send_frame(l_in, r_in);
      end
      drain();
    end
    rx_no_stall = 1'b0;
    tx_no_gap = 1'b0;
  endtask

  initial begin
    build_tables();
    cfg_thr = 64'hEC00;
    cfg_slope = 32768;
    cfg_attack = 655;
    cfg_release = 66;
    cfg_average = 655;
    cfg_wet = 65536;
    cfg_preset = 65536;
    mean_pow = 0;
    gain_state = 65536;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_defaults();
    test_registers();
    test_random_phases(8, 240);

    $display("Covered %0d frames and %0d results under %0d register writes,", frames_sent,
             frames_checked, cfg_writes);
    $display("from reset defaults through extreme and random settings.");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
